// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and coefficient unpacking for the barometric
// pressure / temperature compensation unit.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int RAW_BITS_DEF      = 24;
  localparam int OUT_FRAC_BITS_DEF = 8;
  localparam int QF                = 29;
  localparam int MAG_W             = 24;
  localparam int CFG_AW            = 6;
  localparam int CFG_DW            = 64;
  localparam int QDEPTH            = 2;

  localparam logic [23:0] SCALE_RESET = 24'd7864320;

  localparam logic [2:0] REG_COEF_LO  = 3'd0;
  localparam logic [2:0] REG_COEF_MID = 3'd1;
  localparam logic [2:0] REG_COEF_HI  = 3'd2;
  localparam logic [2:0] REG_P_SCALE  = 3'd3;
  localparam logic [2:0] REG_T_SCALE  = 3'd4;

  typedef struct packed {
    logic              p_neg;
    logic [MAG_W-1:0]  p_mag;
    logic              t_neg;
    logic [MAG_W-1:0]  t_mag;
  } item_t;

  typedef struct packed {
    logic               sat;
    logic [31:0]        mag;
    logic signed [31:0] val;
  } div_res_t;

  typedef struct packed {
    logic signed [11:0] c0;
    logic signed [11:0] c1;
    logic signed [19:0] c00;
    logic signed [19:0] c10;
    logic signed [15:0] c01;
    logic signed [15:0] c11;
    logic signed [15:0] c20;
    logic signed [15:0] c21;
    logic signed [15:0] c30;
  } coef_t;

  function automatic coef_t unpack_coef(input logic [47:0] lo, input logic [47:0] mid,
                                        input logic [47:0] hi);
    coef_t c;
    c.c0  = lo[47:36];
    c.c1  = lo[35:24];
    c.c00 = lo[23:4];
    c.c10 = {lo[3:0], mid[47:32]};
    c.c01 = mid[31:16];
    c.c11 = mid[15:0];
    c.c20 = hi[47:32];
    c.c21 = hi[31:16];
    c.c30 = hi[15:0];
    return c;
  endfunction

endpackage

// ===== rtl/bpc_ifs.sv =====
// ----------------------------------------------------------------------------
// bpc_ifs
// Valid/ready channel interfaces for raw samples and compensated results.
// ----------------------------------------------------------------------------
interface bpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] pressure_raw;
  logic signed [23:0] temperature_raw;

  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] temperature_c;
  logic signed [31:0] pressure_out;
  logic               saturated;

  modport source (output valid, output temperature_c, output pressure_out,
                  output saturated, input ready);
  modport sink   (input valid, input temperature_c, input pressure_out,
                  input saturated, output ready);
endinterface

// ===== rtl/bpc_fifo.sv =====
// ----------------------------------------------------------------------------
// bpc_fifo
// Short item queue between the front and back parts.
// ----------------------------------------------------------------------------
module bpc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bpc_pkg::item_t push_item,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output bpc_pkg::item_t pop_item
);
  localparam int AW = (bpc_pkg::QDEPTH > 1) ? $clog2(bpc_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(bpc_pkg::QDEPTH + 1);

  bpc_pkg::item_t mem_r [bpc_pkg::QDEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  cnt_r;

  assign full     = (cnt_r == CW'(bpc_pkg::QDEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == AW'(bpc_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && valid) begin
        rd_ptr_r <= (rd_ptr_r == AW'(bpc_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push && !full) - CW'(pop && valid);
    end
  end
endmodule

// ===== rtl/bpc_div.sv =====
// ----------------------------------------------------------------------------
// bpc_div
// Iterative rounded divider: round(mag * 2^29 / scale), four quotient bits a
// cycle, clipped to signed 32 bits.
// ----------------------------------------------------------------------------
module bpc_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [bpc_pkg::MAG_W-1:0] mag_in,
  input  logic                   neg_in,
  input  logic [23:0]            scale,
  output logic                   done,
  output bpc_pkg::div_res_t      res
);
  localparam int STEPS = 4;
  localparam int ITER  = 32 / STEPS;
  localparam int CW    = $clog2(ITER);
  localparam int NW    = bpc_pkg::MAG_W + bpc_pkg::QF + 1;

  logic [23:0]   d;
  logic [NW-1:0] n;
  logic          ovf;
  logic [24:0]   rem;
  logic [31:0]   sh;

  logic [24:0]   rem_r;
  logic [31:0]   sh_r;
  logic [23:0]   d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic          ovf_r;
  logic          neg_r;
  logic          sat;
  logic [31:0]   mag;

  assign d   = (scale == '0) ? 24'd1 : scale;
  assign n   = NW'({mag_in, {bpc_pkg::QF{1'b0}}}) + NW'(d >> 1);
  assign ovf = 24'(n[NW-1:32]) >= d;

  always_comb begin
    rem = rem_r;
    sh  = sh_r;
    for (int i = 0; i < STEPS; i++) begin
      rem = {rem[23:0], sh[31]};
      sh  = {sh[30:0], 1'b0};
      if (rem >= {1'b0, d_r}) begin
        rem   = rem - {1'b0, d_r};
        sh[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= 25'(n[NW-1:32]);
        sh_r  <= n[31:0];
        d_r   <= d;
        ovf_r <= ovf;
        neg_r <= neg_in;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem;
        sh_r  <= sh;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ITER - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sat = ovf_r || (!neg_r && sh_r[31]) || (neg_r && sh_r[31] && (sh_r[30:0] != '0));
  assign mag = sat ? (neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF) : sh_r;

  assign done    = done_r;
  assign res.sat = sat;
  assign res.mag = mag;
  assign res.val = neg_r ? -$signed(mag) : $signed(mag);
endmodule

// ===== rtl/bpc_front.sv =====
// ----------------------------------------------------------------------------
// bpc_front
// Accepts raw sample pairs, sign-extends them and splits sign and magnitude.
// ----------------------------------------------------------------------------
module bpc_front #(
  parameter int RAW_BITS = bpc_pkg::RAW_BITS_DEF
) (
  bpc_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           q_push,
  output bpc_pkg::item_t q_item
);
  function automatic logic [bpc_pkg::MAG_W:0] classify(input logic [23:0] raw);
    logic signed [23:0] ext;
    ext = 24'(signed'(raw[RAW_BITS-1:0]));
    return {ext[23], ext[23] ? 24'(-ext) : 24'(ext)};
  endfunction

  logic [bpc_pkg::MAG_W:0] p_cls;
  logic [bpc_pkg::MAG_W:0] t_cls;

  assign p_cls = classify(in_ch.pressure_raw);
  assign t_cls = classify(in_ch.temperature_raw);

  assign in_ch.ready  = !q_full;
  assign q_push       = in_ch.valid && !q_full;
  assign q_item.p_neg = p_cls[bpc_pkg::MAG_W];
  assign q_item.p_mag = p_cls[bpc_pkg::MAG_W-1:0];
  assign q_item.t_neg = t_cls[bpc_pkg::MAG_W];
  assign q_item.t_mag = t_cls[bpc_pkg::MAG_W-1:0];
endmodule

// ===== rtl/bpc_back.sv =====
// ----------------------------------------------------------------------------
// bpc_back
// Scales both readings, evaluates the compensation polynomials on one shared
// multiplier and holds the result in an output register.
// ----------------------------------------------------------------------------
module bpc_back #(
  parameter int OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  bpc_pkg::item_t q_item,
  output logic           q_pop,
  input  bpc_pkg::coef_t coef,
  input  logic [23:0]    p_scale,
  input  logic [23:0]    t_scale,
  bpc_out_if.source      out_ch
);
  localparam int          SH  = bpc_pkg::QF - OUT_FRAC_BITS;
  localparam logic [63:0] RND = 64'd1 << (SH - 1);
  localparam logic [63:0] HALF_Q = 64'd1 << (bpc_pkg::QF - 1);
  localparam logic [63:0] T_POS_LIM = 64'h7F_FFFF;
  localparam logic [63:0] T_NEG_LIM = 64'h80_0000;
  localparam logic [63:0] P_POS_LIM = 64'h7FFF_FFFF;
  localparam logic [63:0] P_NEG_LIM = 64'h8000_0000;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_MUL, ST_FIN} state_t;
  typedef enum logic [3:0] {
    OP_TC1, OP_PC30, OP_AH, OP_AL, OP_BH, OP_BL,
    OP_PC01, OP_DC21, OP_EH, OP_EL, OP_DH, OP_DL
  } op_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  state_t             state_r;
  op_t                op_r;
  logic               ph_r;
  logic signed [65:0] prod_r;
  logic signed [63:0] t_r;
  logic signed [63:0] p_r;
  logic [51:0]        mx_r;
  logic [33:0]        my_r;
  logic               mneg_r;
  logic [51:0]        dm_r;
  logic               dneg_r;
  logic [63:0]        hp_r;
  logic signed [31:0] psc_r;
  logic signed [31:0] tsc_r;
  logic [31:0]        pm_r;
  logic [31:0]        tm_r;
  logic               sat_r;
  logic               out_valid_r;
  logic signed [23:0] out_t_r;
  logic signed [31:0] out_p_r;
  logic               out_sat_r;

  logic               div_start;
  logic               p_done;
  logic               t_done;
  bpc_pkg::div_res_t  p_res;
  bpc_pkg::div_res_t  t_res;

  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;

  logic signed [30:0] mul_a;
  logic signed [34:0] mul_b;
  logic [63:0]        lo_prod;
  logic [63:0]        mq;
  logic signed [63:0] mq_s;
  logic signed [63:0] v_a;
  logic signed [63:0] v_b;
  logic signed [63:0] v_d;

  logic [63:0]        t_m, t_rd, t_lim, t_v;
  logic [63:0]        p_m, p_rd, p_lim, p_v;
  logic               out_clip;

  assign c0  = coef.c0;
  assign c1  = coef.c1;
  assign c00 = coef.c00;
  assign c10 = coef.c10;
  assign c01 = coef.c01;
  assign c11 = coef.c11;
  assign c20 = coef.c20;
  assign c21 = coef.c21;
  assign c30 = coef.c30;

  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign div_start = q_pop;

  bpc_div u_div_p (
    .clk(clk), .rst_n(rst_n), .start(div_start), .mag_in(q_item.p_mag),
    .neg_in(q_item.p_neg), .scale(p_scale), .done(p_done), .res(p_res)
  );

  bpc_div u_div_t (
    .clk(clk), .rst_n(rst_n), .start(div_start), .mag_in(q_item.t_mag),
    .neg_in(q_item.t_neg), .scale(t_scale), .done(t_done), .res(t_res)
  );

  always_comb begin
    unique case (op_r)
      OP_TC1: begin
        mul_a = 31'(c1);
        mul_b = 35'(tsc_r);
      end
      OP_PC30: begin
        mul_a = 31'(c30);
        mul_b = 35'(psc_r);
      end
      OP_PC01: begin
        mul_a = 31'(c01);
        mul_b = 35'(tsc_r);
      end
      OP_DC21: begin
        mul_a = 31'(c21);
        mul_b = 35'(psc_r);
      end
      OP_AH, OP_BH, OP_EH, OP_DH: begin
        mul_a = $signed({8'd0, mx_r[51:29]});
        mul_b = $signed({1'b0, my_r});
      end
      default: begin
        mul_a = $signed({2'd0, mx_r[28:0]});
        mul_b = $signed({1'b0, my_r});
      end
    endcase
  end

  // rounded Q29 product from the high and low partial products
  assign lo_prod = prod_r[63:0];
  assign mq      = hp_r + ((lo_prod + HALF_Q) >> bpc_pkg::QF);
  assign mq_s    = mneg_r ? -$signed(mq) : $signed(mq);
  assign v_a     = (64'(c20) <<< bpc_pkg::QF) + 64'(prod_r);
  assign v_b     = (64'(c10) <<< bpc_pkg::QF) + mq_s;
  assign v_d     = (64'(c11) <<< bpc_pkg::QF) + 64'(prod_r);

  always_comb begin
    t_m   = mag64(t_r);
    t_rd  = (t_m + RND) >> SH;
    t_lim = t_r[63] ? T_NEG_LIM : T_POS_LIM;
    t_v   = (t_rd > t_lim) ? t_lim : t_rd;
    p_m   = mag64(p_r);
    p_rd  = (p_m + RND) >> SH;
    p_lim = p_r[63] ? P_NEG_LIM : P_POS_LIM;
    p_v   = (p_rd > p_lim) ? p_lim : p_rd;
    out_clip = (t_rd > t_lim) || (p_rd > p_lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_TC1;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (p_done && t_done) begin
            psc_r   <= p_res.val;
            tsc_r   <= t_res.val;
            pm_r    <= p_res.mag;
            tm_r    <= t_res.mag;
            sat_r   <= p_res.sat || t_res.sat;
            op_r    <= OP_TC1;
            ph_r    <= 1'b0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!ph_r) begin
            prod_r <= 66'(mul_a) * 66'(mul_b);
            ph_r   <= 1'b1;
          end else begin
            ph_r <= 1'b0;
            unique case (op_r)
              OP_TC1: t_r <= (64'(c0) <<< (bpc_pkg::QF - 1)) + 64'(prod_r);
              OP_PC30: begin
                mx_r   <= 52'(mag64(v_a));
                mneg_r <= v_a[63] ^ psc_r[31];
                my_r   <= 34'(pm_r);
              end
              OP_AH, OP_BH, OP_EH, OP_DH: hp_r <= lo_prod;
              OP_AL: begin
                mx_r   <= 52'(mag64(v_b));
                mneg_r <= v_b[63] ^ psc_r[31];
              end
              OP_BL: p_r <= (64'(c00) <<< bpc_pkg::QF) + mq_s;
              OP_PC01: p_r <= p_r + 64'(prod_r);
              OP_DC21: begin
                dm_r   <= 52'(mag64(v_d));
                dneg_r <= v_d[63];
                mx_r   <= 52'(tm_r);
                mneg_r <= tsc_r[31] ^ psc_r[31];
              end
              OP_EL: begin
                mx_r   <= dm_r;
                my_r   <= 34'(mq);
                mneg_r <= dneg_r ^ mneg_r;
              end
              OP_DL: p_r <= p_r + mq_s;
              default: ;
            endcase
            if (op_r == OP_DL) begin
              state_r <= ST_FIN;
            end else begin
              op_r <= op_t'(op_r + 1'b1);
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_t_r     <= 24'(t_r[63] ? 64'd0 - t_v : t_v);
            out_p_r     <= 32'(p_r[63] ? 64'd0 - p_v : p_v);
            out_sat_r   <= sat_r || out_clip;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.temperature_c = out_t_r;
  assign out_ch.pressure_out  = out_p_r;
  assign out_ch.saturated     = out_sat_r;
endmodule

// ===== rtl/baro_pressure_temp_compensate_unit.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensate_unit
// Barometric pressure / temperature compensation: scaled Q3.29 readings,
// linear temperature and cubic pressure polynomial, rounded and clipped.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  in_ch    | in        | valid/ready       | pressure_raw, temperature_raw
//  out_ch   | out       | valid/ready       | temperature_c, pressure_out, saturated
//  cfg      | in        | APB psel/penable  | five registers at 8*i, 64-bit data
//
//  Per item the back part dequeues it, runs both dividers (4 quotient bits
//  a cycle), captures the scaled values, runs 12 products on the single
//  31x35 multiplier (issue then write back), then rounds and clips.
//  The front takes an item every cycle while the 2-entry queue has room.
//  Reset is synchronous, active low; no clearing pass.
//  A stalled output holds its item; the back part waits only at its last cycle.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensate_unit #(
  parameter int RAW_BITS      = bpc_pkg::RAW_BITS_DEF,
  parameter int OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bpc_in_if.sink                     in_ch,
  bpc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bpc_pkg::CFG_AW-1:0] paddr,
  input  logic [bpc_pkg::CFG_DW-1:0] pwdata,
  output logic [bpc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  logic [47:0]    coef_lo_r;
  logic [47:0]    coef_mid_r;
  logic [47:0]    coef_hi_r;
  logic [23:0]    p_scale_r;
  logic [23:0]    t_scale_r;
  logic [2:0]     reg_idx;
  bpc_pkg::coef_t coef;

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  bpc_pkg::item_t q_in;
  bpc_pkg::item_t q_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bpc_pkg::CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_lo_r  <= '0;
      coef_mid_r <= '0;
      coef_hi_r  <= '0;
      p_scale_r  <= bpc_pkg::SCALE_RESET;
      t_scale_r  <= bpc_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        bpc_pkg::REG_COEF_LO:  coef_lo_r  <= pwdata[47:0];
        bpc_pkg::REG_COEF_MID: coef_mid_r <= pwdata[47:0];
        bpc_pkg::REG_COEF_HI:  coef_hi_r  <= pwdata[47:0];
        bpc_pkg::REG_P_SCALE:  p_scale_r  <= pwdata[23:0];
        bpc_pkg::REG_T_SCALE:  t_scale_r  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bpc_pkg::REG_COEF_LO:  prdata = 64'(coef_lo_r);
      bpc_pkg::REG_COEF_MID: prdata = 64'(coef_mid_r);
      bpc_pkg::REG_COEF_HI:  prdata = 64'(coef_hi_r);
      bpc_pkg::REG_P_SCALE:  prdata = 64'(p_scale_r);
      bpc_pkg::REG_T_SCALE:  prdata = 64'(t_scale_r);
      default:               prdata = '0;
    endcase
  end

  assign coef = bpc_pkg::unpack_coef(coef_lo_r, coef_mid_r, coef_hi_r);

  bpc_front #(.RAW_BITS(RAW_BITS)) u_front (
    .in_ch(in_ch), .q_full(q_full), .q_push(q_push), .q_item(q_in)
  );

  bpc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_item(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .pop_item(q_out)
  );

  bpc_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_out), .q_pop(q_pop),
    .coef(coef), .p_scale(p_scale_r), .t_scale(t_scale_r), .out_ch(out_ch)
  );
endmodule

// ===== rtl/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks on the compensation unit: output hold and item balance.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] temperature_c,
  input logic signed [31:0] pressure_out,
  input logic               saturated
);
  logic [2:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(temperature_c) && $stable(pressure_out)
                                && $stable(saturated))
    else $error("stalled output item changed");

  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> pend_r != 3'd0)
    else $error("result item without an accepted input item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("more items in flight than queue and stages can hold");
endmodule

bind baro_pressure_temp_compensate_unit bpc_checker u_bpc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .temperature_c(out_ch.temperature_c),
  .pressure_out(out_ch.pressure_out),
  .saturated(out_ch.saturated)
);
